@@ sv/hbk_pkg.sv @@
`default_nettype none

package hbk_pkg;

  localparam int KEY_SLOTS_DEFAULT = 6;
  localparam int IN_SLOTS = 6;
  localparam int MOD_BITS = 8;
  localparam int ROM_SIZE = 57;

  localparam logic [7:0] HIGHEST_PLACEHOLDER = 8'd3;
  localparam logic [7:0] CODE_A = 8'd4;
  localparam logic [7:0] CODE_Z = 8'd29;
  localparam logic [7:0] CODE_CAPS = 8'h39;
  localparam logic [7:0] CODE_SCROLL = 8'h47;
  localparam logic [7:0] CODE_NUM = 8'h53;
  localparam logic [7:0] SHIFT_LEFT = 8'h02;
  localparam logic [7:0] SHIFT_RIGHT = 8'h20;

  localparam logic [2:0] LED_NUM = 3'b001;
  localparam logic [2:0] LED_CAPS = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b100;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_DISCONNECT = 1'b1;

  typedef logic [7:0] code_t;

  typedef enum logic [1:0] {
    KIND_MOD_PRESS = 2'd0,
    KIND_MOD_RELEASE = 2'd1,
    KIND_KEY_PRESS = 2'd2,
    KIND_KEY_RELEASE = 2'd3
  } kind_t;

  typedef struct packed {
    logic release_key;
    logic press_key;
  } lane_flags_t;

  typedef struct packed {
    logic load;
    logic clear_locks;
  } emit_ctl_t;

  // Returns {unshifted, shifted} characters of a usage code below ROM_SIZE.
  function automatic logic [15:0] char_pair(input logic [5:0] code);
    logic [15:0] pair;
    case (code)
      6'd4: pair = "aA";
      6'd5: pair = "bB";
      6'd6: pair = "cC";
      6'd7: pair = "dD";
      6'd8: pair = "eE";
      6'd9: pair = "fF";
      6'd10: pair = "gG";
      6'd11: pair = "hH";
      6'd12: pair = "iI";
      6'd13: pair = "jJ";
      6'd14: pair = "kK";
      6'd15: pair = "lL";
      6'd16: pair = "mM";
      6'd17: pair = "nN";
      6'd18: pair = "oO";
      6'd19: pair = "pP";
      6'd20: pair = "qQ";
      6'd21: pair = "rR";
      6'd22: pair = "sS";
      6'd23: pair = "tT";
      6'd24: pair = "uU";
      6'd25: pair = "vV";
      6'd26: pair = "wW";
      6'd27: pair = "xX";
      6'd28: pair = "yY";
      6'd29: pair = "zZ";
      6'd30: pair = "1!";
      6'd31: pair = "2@";
      6'd32: pair = "3#";
      6'd33: pair = "4$";
      6'd34: pair = "5%";
      6'd35: pair = "6^";
      6'd36: pair = "7&";
      6'd37: pair = "8*";
      6'd38: pair = "9(";
      6'd39: pair = "0)";
      6'd40: pair = 16'h0D0D;
      6'd42: pair = 16'h0800;
      6'd44: pair = 16'h2020;
      6'd45: pair = "-_";
      6'd46: pair = "=+";
      6'd47: pair = "[{";
      6'd48: pair = "]}";
      6'd49: pair = 16'h5C7C;
      6'd50: pair = 16'h5C7C;
      6'd51: pair = ";:";
      6'd52: pair = 16'h2722;
      6'd53: pair = "`~";
      6'd54: pair = ",<";
      6'd55: pair = ".>";
      6'd56: pair = "/?";
      default: pair = 16'h0000;
    endcase
    return pair;
  endfunction

  function automatic logic [7:0] translate(input logic [7:0] modifier, input code_t code,
                                           input logic caps);
    logic col;
    logic [15:0] pair;
    col = ((modifier & SHIFT_LEFT) != 8'd0) || ((modifier & SHIFT_RIGHT) != 8'd0);
    if (code >= CODE_A && code <= CODE_Z && caps) begin
      col = ~col;
    end
    pair = char_pair(code[5:0]);
    if (code >= 8'(ROM_SIZE)) begin
      return 8'd0;
    end
    return col ? pair[7:0] : pair[15:8];
  endfunction

endpackage

`default_nettype wire

@@ sv/hbk_lane.sv @@
`default_nettype none

module hbk_lane #(
  parameter int KEY_SLOTS = hbk_pkg::KEY_SLOTS_DEFAULT
) (
  input  wire hbk_pkg::code_t                  old_code,
  input  wire hbk_pkg::code_t                  new_code,
  input  wire logic [KEY_SLOTS-1:0][7:0]       old_list,
  input  wire logic [KEY_SLOTS-1:0][7:0]       new_list,
  output hbk_pkg::lane_flags_t                 flags
);

  logic old_found;
  logic new_found;

  always_comb begin
    old_found = 1'b0;
    new_found = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (new_list[i] == old_code) begin
        old_found = 1'b1;
      end
      if (old_list[i] == new_code) begin
        new_found = 1'b1;
      end
    end
    flags.release_key = (old_code > hbk_pkg::HIGHEST_PLACEHOLDER) && !old_found;
    flags.press_key = (new_code > hbk_pkg::HIGHEST_PLACEHOLDER) && !new_found;
  end

endmodule

`default_nettype wire

@@ sv/hbk_emitter.sv @@
`default_nettype none

module hbk_emitter #(
  parameter int KEY_SLOTS = hbk_pkg::KEY_SLOTS_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire hbk_pkg::emit_ctl_t                     ctl,
  input  wire logic [hbk_pkg::MOD_BITS+2*KEY_SLOTS-1:0] pend_in,
  input  wire logic [7:0]                             mod_in,
  input  wire logic [KEY_SLOTS-1:0][7:0]              new_keys_in,
  input  wire logic [KEY_SLOTS-1:0][7:0]              old_keys_in,
  output logic                                        can_take,
  output logic                                        event_valid,
  input  wire logic                                   event_ready,
  output logic [1:0]                                  event_kind,
  output logic [7:0]                                  event_code,
  output logic [7:0]                                  event_modifier,
  output logic [7:0]                                  ascii_char,
  output logic                                        char_valid,
  output logic [2:0]                                  lock_leds,
  output logic                                        leds_changed,
  output logic                                        last
);

  localparam int PW = hbk_pkg::MOD_BITS + 2 * KEY_SLOTS;
  localparam int IW = $clog2(PW);
  localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic [PW-1:0]              pend;
  logic [7:0]                 work_mod;
  logic [KEY_SLOTS-1:0][7:0]  work_new;
  logic [KEY_SLOTS-1:0][7:0]  work_old;
  logic [2:0]                 leds;
  logic [2:0]                 leds_next;

  logic                       emit;
  logic [IW-1:0]              sel;
  logic [IW-1:0]              off;
  logic [SW-1:0]              slot;
  logic [7:0]                 mbit;
  hbk_pkg::kind_t             kind_d;
  hbk_pkg::code_t             code_d;
  logic [7:0]                 mod_d;
  logic [7:0]                 char_d;
  logic [2:0]                 toggle;

  assign emit = (pend != '0) && (!event_valid || event_ready);
  assign can_take = (pend == '0) || ($onehot(pend) && emit);

  always_comb begin
    sel = '0;
    for (int i = PW - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = IW'(i);
      end
    end
  end

  always_comb begin
    off = sel - IW'(hbk_pkg::MOD_BITS);
    slot = SW'(off >> 1);
    mbit = 8'd1 << sel[2:0];
    toggle = 3'b000;
    kind_d = hbk_pkg::KIND_KEY_RELEASE;
    code_d = 8'd0;
    mod_d = 8'd0;
    char_d = 8'd0;
    if (sel < IW'(hbk_pkg::MOD_BITS)) begin
      kind_d = ((work_mod & mbit) != 8'd0) ? hbk_pkg::KIND_MOD_PRESS
                                           : hbk_pkg::KIND_MOD_RELEASE;
      mod_d = mbit;
    end else if (!off[0]) begin
      code_d = work_old[slot];
    end else begin
      kind_d = hbk_pkg::KIND_KEY_PRESS;
      code_d = work_new[slot];
      mod_d = work_mod;
      if (code_d == hbk_pkg::CODE_CAPS) begin
        toggle = hbk_pkg::LED_CAPS;
      end else if (code_d == hbk_pkg::CODE_NUM) begin
        toggle = hbk_pkg::LED_NUM;
      end else if (code_d == hbk_pkg::CODE_SCROLL) begin
        toggle = hbk_pkg::LED_SCROLL;
      end else begin
        char_d = hbk_pkg::translate(work_mod, code_d, leds[1]);
      end
    end
  end

  always_comb begin
    leds_next = emit ? (leds ^ toggle) : leds;
    if (ctl.clear_locks) begin
      leds_next = 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      leds <= 3'b000;
      event_valid <= 1'b0;
    end else begin
      leds <= leds_next;
      if (ctl.load) begin
        pend <= pend_in;
      end else if (emit) begin
        pend <= pend & (pend - 1'b1);
      end
      if (emit) begin
        event_valid <= 1'b1;
      end else if (event_ready) begin
        event_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work_mod <= mod_in;
      work_new <= new_keys_in;
      work_old <= old_keys_in;
    end
    if (emit) begin
      event_kind <= kind_d;
      event_code <= code_d;
      event_modifier <= mod_d;
      ascii_char <= char_d;
      char_valid <= (char_d != 8'd0);
      lock_leds <= leds ^ toggle;
      leds_changed <= (toggle != 3'b000);
      last <= $onehot(pend);
    end
  end

  a_lock_only_on_press: assert property (@(posedge clk) disable iff (rst)
    event_valid && leds_changed |-> event_kind == hbk_pkg::KIND_KEY_PRESS && !char_valid)
    else $error("lock toggle reported on a beat that is not a plain key press");

  a_mod_beat_no_code: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == hbk_pkg::KIND_MOD_PRESS ||
                    event_kind == hbk_pkg::KIND_MOD_RELEASE)
    |-> event_code == 8'd0 && $onehot(event_modifier) && !char_valid)
    else $error("modifier beat carries a code, a character or several bits");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    $countones(pend) > 1 |-> !can_take)
    else $error("new report taken while several events are still pending");

  a_leds_follow_toggle: assert property (@(posedge clk) disable iff (rst)
    emit && !ctl.clear_locks |=> leds == lock_leds)
    else $error("lock flags differ from the LED mask of the last beat");

endmodule

`default_nettype wire

@@ sv/hid_boot_keyboard_report_decoder.sv @@
// Boot keyboard report decoder.
// The report channel (report_valid / report_ready) carries one beat per boot
// keyboard report or disconnect request, selected by req_type. The event
// channel (event_valid / event_ready) carries one beat per key event.
// A report yields its modifier events first, from bit 0 up, then per slot
// a release of a vanished key and a press of a new key, with the last beat
// flagged. Lock key presses toggle the caps, num and scroll flags.
// The edge that takes a report loads the pending events; the first is then
// registered into the output register, after which the sequencer issues one
// event per cycle while event_ready is high. report_ready stays low while
// more than one event is pending and stays high for a report or disconnect
// without events; the next report is taken in the cycle the last event of
// the previous one is issued. When the receiver stalls, the current event
// stays in the output register and the sequencer waits; report_ready falls
// once pending events remain. Reset clears stored keys, modifier byte, lock
// flags and pending events; a disconnect clears the lock flags only.
`default_nettype none

module hid_boot_keyboard_report_decoder #(
  parameter int KEY_SLOTS = hbk_pkg::KEY_SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        report_valid,
  output logic             report_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  report_modifier,
  input  wire logic [7:0]  slot0_code,
  input  wire logic [7:0]  slot1_code,
  input  wire logic [7:0]  slot2_code,
  input  wire logic [7:0]  slot3_code,
  input  wire logic [7:0]  slot4_code,
  input  wire logic [7:0]  slot5_code,
  output logic             event_valid,
  input  wire logic        event_ready,
  output logic [1:0]       event_kind,
  output logic [7:0]       event_code,
  output logic [7:0]       event_modifier,
  output logic [7:0]       ascii_char,
  output logic             char_valid,
  output logic [2:0]       lock_leds,
  output logic             leds_changed,
  output logic             last
);

  localparam int PW = hbk_pkg::MOD_BITS + 2 * KEY_SLOTS;

  logic [hbk_pkg::IN_SLOTS-1:0][7:0] in_slots;
  logic [KEY_SLOTS-1:0][7:0]         keys;
  logic [KEY_SLOTS-1:0][7:0]         stored_keys;
  logic [7:0]                        prev_mod;
  hbk_pkg::lane_flags_t              lane_flags [KEY_SLOTS];
  logic [PW-1:0]                     pend_in;
  logic                              accept;
  hbk_pkg::emit_ctl_t                ctl;

  assign in_slots = {slot5_code, slot4_code, slot3_code, slot2_code, slot1_code, slot0_code};

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    if (g < hbk_pkg::IN_SLOTS) begin : g_real
      assign keys[g] = in_slots[g];
    end else begin : g_pad
      assign keys[g] = 8'd0;
    end

    hbk_lane #(
      .KEY_SLOTS(KEY_SLOTS)
    ) u_lane (
      .old_code(stored_keys[g]),
      .new_code(keys[g]),
      .old_list(stored_keys),
      .new_list(keys),
      .flags   (lane_flags[g])
    );

    assign pend_in[hbk_pkg::MOD_BITS + 2 * g] = lane_flags[g].release_key;
    assign pend_in[hbk_pkg::MOD_BITS + 2 * g + 1] = lane_flags[g].press_key;
  end

  assign pend_in[hbk_pkg::MOD_BITS-1:0] = report_modifier ^ prev_mod;

  assign accept = report_valid && report_ready;
  assign ctl.load = accept && (req_type == hbk_pkg::REQ_REPORT);
  assign ctl.clear_locks = accept && (req_type == hbk_pkg::REQ_DISCONNECT);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_keys <= '0;
      prev_mod <= 8'd0;
    end else if (ctl.load) begin
      stored_keys <= keys;
      prev_mod <= report_modifier;
    end
  end

  hbk_emitter #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_emitter (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .pend_in       (pend_in),
    .mod_in        (report_modifier),
    .new_keys_in   (keys),
    .old_keys_in   (stored_keys),
    .can_take      (report_ready),
    .event_valid   (event_valid),
    .event_ready   (event_ready),
    .event_kind    (event_kind),
    .event_code    (event_code),
    .event_modifier(event_modifier),
    .ascii_char    (ascii_char),
    .char_valid    (char_valid),
    .lock_leds     (lock_leds),
    .leds_changed  (leds_changed),
    .last          (last)
  );

endmodule

`default_nettype wire
